/* hdl/rgbh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgbh_pkg: shared types and constants for the RGB to hue converter
// Sector codes, degree constants and the threshold register format.
// ----------------------------------------------------------------------------
package rgbh_pkg;

	// threshold register
	localparam int MIN_CHROMA_W = 12;
	localparam logic [MIN_CHROMA_W-1:0] MIN_CHROMA_RESET = 12'd1;

	// degrees per sixth of a turn, and a full turn
	localparam int DEG_W = 6;
	localparam logic [DEG_W-1:0] DEG_PER_SECTOR = 6'd60;
	localparam int DEG_FULL_TURN = 360;

	// which channel holds the maximum
	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

endpackage
`default_nettype wire

/* hdl/rgb_to_hue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hue: HSV hue of one pixel
// Pipelined max/min, sector numerator, scale by 60 and restoring divide.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, unless the output stalls, and returns its HSV
// hue in degrees with HUE_FRAC_BITS fraction bits, floored. The pipeline has
// one stage for max/min and chroma, one for the sector numerator, one for the
// multiply by 60, one per quotient bit in the restoring divider, and the
// output register. Throughput is one pixel per cycle while the output is not
// stalled. The input side has a skid register, so s_axis_tready is a flop
// output. Chroma below min_chroma (or zero) sets tuser and forces hue to 0.
module rgb_to_hue #(
	parameter int CHANNEL_FRAC_BITS = 4,
	parameter int HUE_FRAC_BITS = 6,
	localparam int CHAN_W = 8 + CHANNEL_FRAC_BITS,
	localparam int HUE_W = 9 + HUE_FRAC_BITS,
	localparam int IN_TDATA_W = ((3 * CHAN_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((HUE_W + 7) / 8) * 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]             s_axis_tdata,  // blue, green, red
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [OUT_TDATA_W-1:0]                 m_axis_tdata,  // hue
	output logic [0:0]                             m_axis_tuser,  // hue_undefined
	input  wire logic                              cfg_wr_en,
	input  wire logic [rgbh_pkg::MIN_CHROMA_W-1:0] cfg_wr_data    // min_chroma
);
	import rgbh_pkg::*;

	localparam int NUM_W = CHAN_W + 3;
	localparam int PROD_W = NUM_W + DEG_W;
	localparam int DIV_W = PROD_W + HUE_FRAC_BITS;
	localparam int CMP_W = (CHAN_W > MIN_CHROMA_W) ? CHAN_W : MIN_CHROMA_W;
	localparam int PIX_W = 3 * CHAN_W;

	logic [MIN_CHROMA_W-1:0] min_chroma_q;

	logic             en;
	logic             skid_full_q;
	logic [PIX_W-1:0] skid_data_q;
	logic             in_fire;
	logic [PIX_W-1:0] pipe_in;
	logic             pipe_in_v;

	logic [CHAN_W-1:0] b_in, g_in, r_in, hi_in, lo_in;
	sector_t           sec_in;

	logic              v_s1;
	logic [CHAN_W-1:0] c_s1, b_s1, g_s1, r_s1;
	sector_t           sec_s1;

	logic [NUM_W-1:0]  num_nx;
	logic              undef_nx;
	logic              v_s2;
	logic [CHAN_W-1:0] c_s2;
	logic [NUM_W-1:0]  num_s2;
	logic              undef_s2;

	logic [PROD_W-1:0] prod;
	logic [DIV_W-1:0]  dividend;

	// divider stages; index 0 is the third pipeline stage
	logic              div_v_s     [0:HUE_W];
	logic              div_undef_s [0:HUE_W];
	logic [CHAN_W-1:0] div_c_s     [0:HUE_W];
	logic [CHAN_W-1:0] div_rem_s   [0:HUE_W];
	logic [HUE_W-1:0]  div_low_s   [0:HUE_W];
	logic [HUE_W-1:0]  div_q_s     [0:HUE_W];

	logic [CHAN_W-1:0] rem_nx [1:HUE_W];
	logic              qbit_nx [1:HUE_W];

	logic             out_v_q;
	logic [HUE_W-1:0] hue_q;
	logic             undef_q;

	// ------------------------------------------------------------------
	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_chroma_q <= MIN_CHROMA_RESET;
		end else if (cfg_wr_en) begin
			min_chroma_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// input skid; the whole pipe moves when the output slot frees up
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = !skid_full_q;
	assign in_fire = s_axis_tvalid && !skid_full_q;
	assign pipe_in = skid_full_q ? skid_data_q : s_axis_tdata[PIX_W-1:0];
	assign pipe_in_v = skid_full_q || in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (in_fire) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_fire) begin
			skid_data_q <= s_axis_tdata[PIX_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// stage 1: sector, chroma
	assign b_in = pipe_in[CHAN_W-1:0];
	assign g_in = pipe_in[2*CHAN_W-1:CHAN_W];
	assign r_in = pipe_in[3*CHAN_W-1:2*CHAN_W];

	always_comb begin
		// ties go to red, then green
		if (r_in >= g_in && r_in >= b_in) begin
			sec_in = SEC_RED;
		end else if (g_in >= b_in) begin
			sec_in = SEC_GREEN;
		end else begin
			sec_in = SEC_BLUE;
		end
		case (sec_in)
			SEC_RED:   hi_in = r_in;
			SEC_GREEN: hi_in = g_in;
			SEC_BLUE:  hi_in = b_in;
			default:   hi_in = r_in;
		endcase
		lo_in = (b_in < g_in) ? b_in : g_in;
		lo_in = (r_in < lo_in) ? r_in : lo_in;
	end

	// ------------------------------------------------------------------
	// stage 2: numerator in sixths of a turn, times chroma
	always_comb begin
		case (sec_s1)
			SEC_RED: begin
				if (g_s1 >= b_s1) begin
					num_nx = NUM_W'(g_s1) - NUM_W'(b_s1);
				end else begin
					// negative side wraps by a full turn
					num_nx = (NUM_W'(c_s1) << 2) + (NUM_W'(c_s1) << 1)
						+ NUM_W'(g_s1) - NUM_W'(b_s1);
				end
			end
			SEC_GREEN: num_nx = (NUM_W'(c_s1) << 1) + NUM_W'(b_s1) - NUM_W'(r_s1);
			SEC_BLUE:  num_nx = (NUM_W'(c_s1) << 2) + NUM_W'(r_s1) - NUM_W'(g_s1);
			default:   num_nx = '0;
		endcase
		undef_nx = (c_s1 == '0) || (CMP_W'(c_s1) < CMP_W'(min_chroma_q));
	end

	// stage 3 input: scale by 60 and by the hue fraction
	assign prod = PROD_W'(num_s2) * PROD_W'(DEG_PER_SECTOR);
	assign dividend = DIV_W'(prod) << HUE_FRAC_BITS;

	// ------------------------------------------------------------------
	// restoring divider, one quotient bit per stage
	always_comb begin
		for (int k = 1; k <= HUE_W; k++) begin
			logic [CHAN_W:0] trial;
			trial = {div_rem_s[k-1], div_low_s[k-1][HUE_W-1]};
			qbit_nx[k] = (trial >= {1'b0, div_c_s[k-1]});
			if (qbit_nx[k]) begin
				rem_nx[k] = CHAN_W'(trial - {1'b0, div_c_s[k-1]});
			end else begin
				rem_nx[k] = trial[CHAN_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k <= HUE_W; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= pipe_in_v;
			v_s2 <= v_s1;
			div_v_s[0] <= v_s2;
			for (int k = 1; k <= HUE_W; k++) begin
				div_v_s[k] <= div_v_s[k-1];
			end
			out_v_q <= div_v_s[HUE_W];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1 <= sec_in;
			c_s1 <= hi_in - lo_in;
			b_s1 <= b_in;
			g_s1 <= g_in;
			r_s1 <= r_in;

			c_s2 <= c_s1;
			num_s2 <= num_nx;
			undef_s2 <= undef_nx;

			// remainder starts with the top bits; always below chroma
			div_c_s[0] <= c_s2;
			div_undef_s[0] <= undef_s2;
			div_rem_s[0] <= dividend[DIV_W-1:HUE_W];
			div_low_s[0] <= dividend[HUE_W-1:0];
			div_q_s[0] <= '0;
			for (int k = 1; k <= HUE_W; k++) begin
				div_c_s[k] <= div_c_s[k-1];
				div_undef_s[k] <= div_undef_s[k-1];
				div_rem_s[k] <= rem_nx[k];
				div_low_s[k] <= div_low_s[k-1] << 1;
				div_q_s[k] <= {div_q_s[k-1][HUE_W-2:0], qbit_nx[k]};
			end

			undef_q <= div_undef_s[HUE_W];
			hue_q <= div_undef_s[HUE_W] ? '0 : div_q_s[HUE_W];
		end
	end

	// ------------------------------------------------------------------
	// output
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = OUT_TDATA_W'(hue_q);
	assign m_axis_tuser = undef_q;

`ifndef SYNTH
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("undefined hue transfer with nonzero hue");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0]
		|-> hue_q < HUE_W'(DEG_FULL_TURN << HUE_FRAC_BITS))
		else $error("hue at or above a full turn");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[HUE_W] && !div_undef_s[HUE_W] |-> div_rem_s[HUE_W] < div_c_s[HUE_W])
		else $error("divider remainder not below chroma");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && en |=> !skid_full_q && v_s1)
		else $error("skid entry not moved into the pipe");
`endif

endmodule
`default_nettype wire
